// ----- hw/rtl/gn_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn_pkg: shared types and constants for the group normalization block
// Holds field widths, configuration register indexes, item kinds, the queue
// entry format and the back-end state encoding.
// ----------------------------------------------------------------------------
package gn_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned CHAN_W     = 6;
  localparam int unsigned NUM_CHAN   = 64;
  localparam int unsigned MAX_PLANE  = 4096;
  localparam int unsigned PLANE_W    = 13;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned MAX_ELEMS  = 262144;
  localparam int unsigned CNT_W      = 19;
  localparam int unsigned SUM_W      = 35;
  localparam int unsigned SUMSQ_W    = 51;
  localparam int unsigned EPS_W      = 16;
  localparam int unsigned INV_W      = 24;
  localparam int unsigned DVD_W      = 51;
  localparam int unsigned DVS_W      = 33;
  localparam int unsigned SQRT_W     = 49;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TDATA_W    = 56;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON    = 1'd1;

  // item kinds, also used as the queued operation
  typedef enum logic [1:0] {
    KIND_AFFINE = 2'd0,
    KIND_STAT   = 2'd1,
    KIND_NORM   = 2'd2
  } gn_kind_e;

  // one queued operation
  typedef struct packed {
    gn_kind_e                   op;
    logic signed [SAMPLE_W-1:0] sample;
    logic [CHAN_W-1:0]          chan;
    logic signed [SAMPLE_W-1:0] gamma;
    logic signed [SAMPLE_W-1:0] beta;
    logic                       last;
  } gn_cmd_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic    empty;
    gn_cmd_t head;
  } gn_queue_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_N1,
    ST_N2,
    ST_N3,
    ST_MSTART,
    ST_MWAIT,
    ST_ESTART,
    ST_EWAIT,
    ST_VAR,
    ST_RSTART,
    ST_RWAIT,
    ST_SQRT,
    ST_FIN
  } gn_state_e;

endpackage

// ----- hw/rtl/group_norm_two_pass.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// group_norm_two_pass: two-pass group normalization
// Usage:
//   s_axis carries items; tuser is the kind (affine load, statistics sample,
//   normalize sample), tlast marks the last sample of a pass. Affine loads
//   fill per-channel gamma/beta; statistics items accumulate sum and sum of
//   squares; the last one triggers mean, variance and reciprocal root.
//   m_axis returns one result per normalize item, tlast on the group's end,
//   tuser set when the value saturated.
//   Configure plane_size and epsilon on the cfg port while idle.
// Sequence:
//   Affine and statistics items are done as the back end pops them;
//   normalize items go through table read, two multiplies and round/saturate.
//   The end of a statistics pass runs the bit-serial divider for the mean and
//   the mean square and, unless variance plus epsilon is zero, for 2^48 over
//   that sum, followed by the 25-step square root; items queue meanwhile.
// Reset clears statistics, counters, mean and reciprocal root; tables are
// undefined until loaded. A stalled receiver holds the output register; the
// queue keeps taking items until it fills, then tready drops.
// ----------------------------------------------------------------------------
module group_norm_two_pass import gn_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // sample[15:0], channel[21:16], gamma_in[37:22], beta_in[53:38], pad
  input  logic [TDATA_W-1:0]    s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]            s_axis_tuser,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // value[15:0]
  output logic [SAMPLE_W-1:0]   m_axis_tdata,
  // clipped[0]
  output logic                  m_axis_tuser,
  output logic                  m_axis_tlast
);

  logic [PLANE_W-1:0] plane_size_q;
  logic [EPS_W-1:0]   epsilon_q;
  logic               push, q_full, pop;
  gn_cmd_t            cmd;
  gn_queue_t          queue;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_size_q <= PLANE_W'(1);
      epsilon_q    <= EPS_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PLANE_SIZE: plane_size_q <= cfg_data_i[PLANE_W-1:0];
        CFG_EPSILON:    epsilon_q    <= cfg_data_i[EPS_W-1:0];
        default:        epsilon_q    <= epsilon_q;
      endcase
    end
  end

  gn_front u_front (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .s_axis_tlast,
    .plane_size_i (plane_size_q),
    .q_full_i     (q_full),
    .push_o       (push),
    .cmd_o        (cmd)
  );

  gn_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .cmd_i   (cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .queue_o (queue)
  );

  gn_back u_back (
    .clk_i,
    .rst_ni,
    .queue_i     (queue),
    .pop_o       (pop),
    .epsilon_i   (epsilon_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_value_o (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_clip_o  (m_axis_tuser)
  );

endmodule

// ----- hw/rtl/gn_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn_front: input classification
// Accepts items, drops unknown kinds, tags normalize items with their channel
// by counting plane positions, and pushes operations into the queue.
// ----------------------------------------------------------------------------
module gn_front import gn_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,
  input  logic [1:0]         s_axis_tuser,
  input  logic               s_axis_tlast,
  input  logic [PLANE_W-1:0] plane_size_i,
  input  logic               q_full_i,
  output logic               push_o,
  output gn_cmd_t            cmd_o
);

  logic [POS_W-1:0]   plane_pos_q, plane_pos_d;
  logic [CHAN_W-1:0]  chan_pos_q, chan_pos_d;
  logic [PLANE_W-1:0] ps;
  logic [PLANE_W-1:0] pos_inc;
  logic               accept, is_affine, is_stat, is_norm;

  assign s_axis_tready = !q_full_i;
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign is_affine = (s_axis_tuser == KIND_AFFINE);
  assign is_stat   = (s_axis_tuser == KIND_STAT);
  assign is_norm   = (s_axis_tuser == KIND_NORM);
  assign push_o    = accept && (is_affine || is_stat || is_norm);

  // build the queue entry
  always_comb begin
    cmd_o.op     = is_affine ? KIND_AFFINE : (is_stat ? KIND_STAT : KIND_NORM);
    cmd_o.sample = s_axis_tdata[15:0];
    cmd_o.chan   = is_norm ? chan_pos_q : s_axis_tdata[21:16];
    cmd_o.gamma  = s_axis_tdata[37:22];
    cmd_o.beta   = s_axis_tdata[53:38];
    cmd_o.last   = s_axis_tlast && !is_affine;
  end

  // clamp plane size to 1..MAX_PLANE
  always_comb begin
    ps = plane_size_i;
    if (plane_size_i == '0) begin
      ps = PLANE_W'(1);
    end else if (plane_size_i > PLANE_W'(MAX_PLANE)) begin
      ps = PLANE_W'(MAX_PLANE);
    end
  end

  // position counters, channel wraps with its width
  always_comb begin
    pos_inc     = {1'b0, plane_pos_q} + PLANE_W'(1);
    plane_pos_d = plane_pos_q;
    chan_pos_d  = chan_pos_q;
    if (accept && is_norm) begin
      if (s_axis_tlast) begin
        plane_pos_d = '0;
        chan_pos_d  = '0;
      end else if (pos_inc >= ps) begin
        plane_pos_d = '0;
        chan_pos_d  = chan_pos_q + CHAN_W'(1);
      end else begin
        plane_pos_d = pos_inc[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_pos_q <= '0;
      chan_pos_q  <= '0;
    end else begin
      plane_pos_q <= plane_pos_d;
      chan_pos_q  <= chan_pos_d;
    end
  end

endmodule

// ----- hw/rtl/gn_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn_fifo: operation queue
// Short first-in first-out queue between the front and back ends.
// DEPTH must be a power of two, at least 2.
// ----------------------------------------------------------------------------
module gn_fifo import gn_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  gn_cmd_t   cmd_i,
  output logic      full_o,
  input  logic      pop_i,
  output gn_queue_t queue_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  gn_cmd_t         mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q, count_d;
  logic            do_push, do_pop;

  assign full_o        = (count_q == CW'(DEPTH));
  assign queue_o.empty = (count_q == '0);
  assign queue_o.head  = mem_q[rd_ptr_q];
  assign do_push       = push_i && !full_o;
  assign do_pop        = pop_i && !queue_o.empty;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ----- hw/rtl/gn_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, DVD_W quotient bits per divide.
// ----------------------------------------------------------------------------
module gn_div import gn_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o,
  output logic [DVS_W-1:0] remainder_o
);

  localparam int unsigned IW = $clog2(DVD_W);

  logic             busy_q, done_q;
  logic [IW-1:0]    cnt_q;
  logic [DVD_W-1:0] dvd_q;
  logic [DVS_W-1:0] dvs_q, rem_q;
  logic [DVS_W:0]   rem_sh, rem_sub;
  logic             qbit;

  // one shift-subtract step
  always_comb begin
    rem_sh  = {rem_q, dvd_q[DVD_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    qbit    = (rem_sh >= {1'b0, dvs_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= IW'(DVD_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - IW'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], qbit};
      rem_q <= qbit ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;

endmodule

// ----- hw/rtl/gn_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn_back: execution of queued operations
// Writes the affine tables, accumulates statistics, runs the end-of-pass
// mean / variance / reciprocal root sequence and the normalize datapath.
// ----------------------------------------------------------------------------
module gn_back import gn_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gn_queue_t           queue_i,
  output logic                pop_o,
  input  logic [EPS_W-1:0]    epsilon_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [SAMPLE_W-1:0] out_value_o,
  output logic                out_last_o,
  output logic                out_clip_o
);

  gn_state_e state_q, state_d;

  // statistics and group results
  logic signed [SUM_W-1:0]    sum_q;
  logic [SUMSQ_W-1:0]         sumsq_q;
  logic [CNT_W-1:0]           cnt_q;
  logic signed [SAMPLE_W-1:0] mean_q;
  logic [INV_W-1:0]           inv_root_q;

  // finish sequence
  logic [CNT_W-1:0]  n_q;
  logic [31:0]       msq_q;
  logic [DVS_W-1:0]  e2_q, v_q;
  logic [SQRT_W-1:0] sx_q, sr_q, sbit_q;
  logic [SQRT_W:0]   strial;

  // normalize path
  gn_cmd_t                    cur_q;
  logic signed [SAMPLE_W-1:0] gamma_rd_q, beta_rd_q;
  logic signed [41:0]         prod1_q;
  logic signed [57:0]         prod2_q;
  logic signed [59:0]         p_full;
  logic signed [31:0]         y_full;
  logic [SAMPLE_W-1:0]        y_sat;
  logic                       y_clip;

  // output register
  logic                out_valid_q;
  logic [SAMPLE_W-1:0] out_value_q;
  logic                out_last_q, out_clip_q;
  logic                out_free, out_load;

  // affine tables
  logic signed [SAMPLE_W-1:0] gamma_mem [NUM_CHAN];
  logic signed [SAMPLE_W-1:0] beta_mem  [NUM_CHAN];

  // divider
  logic             div_start, div_busy, div_done;
  logic [DVD_W-1:0] div_dvd, div_quo;
  logic [DVS_W-1:0] div_dvs, div_rem;

  logic [SUM_W-1:0]     sum_abs;
  logic [16:0]          q_mag, q_adj;
  logic signed [31:0]   sq;
  logic [DVS_W-1:0]     var_w;

  gn_div u_div (
    .clk_i,
    .rst_ni,
    .start_i     (div_start),
    .dividend_i  (div_dvd),
    .divisor_i   (div_dvs),
    .busy_o      (div_busy),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (!queue_i.empty) begin
          if (queue_i.head.op == KIND_NORM) begin
            state_d = ST_N1;
          end else if (queue_i.head.op == KIND_STAT && queue_i.head.last) begin
            state_d = ST_MSTART;
          end
        end
      end
      ST_N1:     state_d = ST_N2;
      ST_N2:     state_d = ST_N3;
      ST_N3:     if (out_free) state_d = ST_IDLE;
      ST_MSTART: state_d = ST_MWAIT;
      ST_MWAIT:  if (div_done) state_d = ST_ESTART;
      ST_ESTART: state_d = ST_EWAIT;
      ST_EWAIT:  if (div_done) state_d = ST_VAR;
      ST_VAR:    state_d = ST_RSTART;
      ST_RSTART: state_d = (v_q == '0) ? ST_FIN : ST_RWAIT;
      ST_RWAIT:  if (div_done) state_d = ST_SQRT;
      ST_SQRT:   if (sbit_q == '0) state_d = ST_FIN;
      ST_FIN:    state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_o     = (state_q == ST_IDLE) && !queue_i.empty;
    out_load  = (state_q == ST_N3) && out_free;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = {{(DVS_W-CNT_W){1'b0}}, n_q};
    case (state_q)
      ST_MSTART: begin
        // count is final here, n_q loads on this same edge
        div_start = 1'b1;
        div_dvd   = {{(DVD_W-SUM_W){1'b0}}, sum_abs};
        div_dvs   = {{(DVS_W-CNT_W){1'b0}}, (cnt_q == '0) ? CNT_W'(1) : cnt_q};
      end
      ST_ESTART: begin
        div_start = 1'b1;
        div_dvd   = sumsq_q;
      end
      ST_RSTART: begin
        div_start = (v_q != '0);
        div_dvd   = DVD_W'(1) << 48;
        div_dvs   = v_q;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // datapath helpers
  always_comb begin
    sum_abs = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
    q_mag   = div_quo[16:0];
    q_adj   = q_mag + 17'(div_rem != '0);
    sq      = queue_i.head.sample * queue_i.head.sample;
    var_w   = (e2_q > {1'b0, msq_q}) ? (e2_q - {1'b0, msq_q}) : '0;
    strial  = {1'b0, sr_q} + {1'b0, sbit_q};
    p_full  = {{2{prod2_q[57]}}, prod2_q}
            + ({{44{beta_rd_q[SAMPLE_W-1]}}, beta_rd_q} <<< 28)
            + (60'sd1 <<< 27);
    y_full  = p_full[59:28];
    y_clip  = !((y_full[31:15] == '0) || (y_full[31:15] == '1));
    if (y_clip) begin
      y_sat = y_full[31] ? 16'h8000 : 16'h7FFF;
    end else begin
      y_sat = y_full[15:0];
    end
  end

  // control state and group statistics
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      sumsq_q     <= '0;
      cnt_q       <= '0;
      mean_q      <= '0;
      inv_root_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o && queue_i.head.op == KIND_STAT && cnt_q < CNT_W'(MAX_ELEMS)) begin
        sum_q   <= sum_q + SUM_W'(queue_i.head.sample);
        sumsq_q <= sumsq_q + SUMSQ_W'(unsigned'(sq));
        cnt_q   <= cnt_q + CNT_W'(1);
      end
      if (state_q == ST_MWAIT && div_done) begin
        mean_q <= sum_q[SUM_W-1] ? SAMPLE_W'(-q_adj) : SAMPLE_W'(q_mag);
      end
      if (state_q == ST_FIN) begin
        if (v_q == '0 || sr_q[SQRT_W-1:INV_W] != '0) begin
          inv_root_q <= '1;
        end else begin
          inv_root_q <= sr_q[INV_W-1:0];
        end
        sum_q   <= '0;
        sumsq_q <= '0;
        cnt_q   <= '0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= queue_i.head;
    end
    if (state_q == ST_MSTART) begin
      n_q <= (cnt_q == '0) ? CNT_W'(1) : cnt_q;
    end
    if (state_q == ST_ESTART) begin
      msq_q <= unsigned'(32'(mean_q * mean_q));
    end
    if (state_q == ST_EWAIT && div_done) begin
      e2_q <= div_quo[DVS_W-1:0];
    end
    if (state_q == ST_VAR) begin
      v_q <= var_w + DVS_W'(epsilon_i);
    end
    // bitwise square root of 2^48 / v
    if (state_q == ST_RWAIT && div_done) begin
      sx_q   <= div_quo[SQRT_W-1:0];
      sr_q   <= '0;
      sbit_q <= SQRT_W'(1) << 48;
    end else if (state_q == ST_SQRT && sbit_q != '0) begin
      if ({1'b0, sx_q} >= strial) begin
        sx_q <= sx_q - strial[SQRT_W-1:0];
        sr_q <= (sr_q >> 1) + sbit_q;
      end else begin
        sr_q <= sr_q >> 1;
      end
      sbit_q <= sbit_q >> 2;
    end
    if (state_q == ST_N1) begin
      prod1_q <= ($signed({cur_q.sample[SAMPLE_W-1], cur_q.sample})
               - $signed({mean_q[SAMPLE_W-1], mean_q}))
               * $signed({1'b0, inv_root_q});
    end
    if (state_q == ST_N2) begin
      prod2_q <= prod1_q * gamma_rd_q;
    end
    if (out_load) begin
      out_value_q <= y_sat;
      out_last_q  <= cur_q.last;
      out_clip_q  <= y_clip;
    end
  end

  // affine tables, registered read
  always_ff @(posedge clk_i) begin
    if (pop_o && queue_i.head.op == KIND_AFFINE) begin
      gamma_mem[queue_i.head.chan] <= queue_i.head.gamma;
      beta_mem[queue_i.head.chan]  <= queue_i.head.beta;
    end
    if (pop_o) begin
      gamma_rd_q <= gamma_mem[queue_i.head.chan];
      beta_rd_q  <= beta_mem[queue_i.head.chan];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;
  assign out_clip_o  = out_clip_q;

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider restarted while busy");

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_ELEMS)) else $error("statistics count overrun");

  a_fin_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN |=> (cnt_q == '0 && sum_q == '0 && sumsq_q == '0))
    else $error("accumulators not cleared after finish");

  a_inv_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN |=> inv_root_q != '0) else $error("zero reciprocal root");

  a_sqrt_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SQRT |-> $onehot0(sbit_q)) else $error("root step bit corrupt");

endmodule

// ----- tb/sv/group_norm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// group_norm_checker: scoreboard for the two-pass group normalization block
// Watches the config port and both streams, keeps its own copy of the
// statistics, tables and position counters, predicts one result per
// normalize item and compares each output item field by field, in order.
// ----------------------------------------------------------------------------
module group_norm_checker import gn_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [TDATA_W-1:0]    s_axis_tdata,
  input  logic [1:0]            s_axis_tuser,
  input  logic                  s_axis_tlast,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [SAMPLE_W-1:0]   m_axis_tdata,
  input  logic                  m_axis_tuser,
  input  logic                  m_axis_tlast,
  output int                    fail_count,
  output int                    pending,
  output int                    result_count,
  output int                    clip_count
);

  typedef struct {
    logic [SAMPLE_W-1:0] value;
    logic                eog;
    logic                clip;
  } norm_result_t;

  norm_result_t want_q[$];

  // shadow of the block state
  logic [PLANE_W-1:0]         plane_reg;
  logic [EPS_W-1:0]           eps_reg;
  longint                     sum_x;
  longint unsigned            sum_x2;
  int unsigned                n_stat;
  longint                     mean_q;
  longint                     inv_std;
  int unsigned                pos_in_plane;
  int unsigned                cur_chan;
  logic signed [SAMPLE_W-1:0] gamma_tbl [NUM_CHAN];
  logic signed [SAMPLE_W-1:0] beta_tbl  [NUM_CHAN];

  initial begin
    fail_count   = 0;
    pending      = 0;
    result_count = 0;
    clip_count   = 0;
  end

  // floor of the square root, bit by bit
  function automatic longint unsigned floor_root(longint unsigned x);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic report(string what, longint want, longint got);
    $display("[%0t] mismatch %s: expected %0h, got %0h", $realtime, what, want, got);
    fail_count++;
  endtask

  // input side: update shadow state, queue expected results
  always @(posedge clk_i) begin : predict
    logic signed [SAMPLE_W-1:0] x;
    logic [CHAN_W-1:0]          ch;
    longint                     q, d, p, y;
    longint unsigned            n, e2, msq, var_v, v, r;
    int unsigned                ps;
    norm_result_t               res;
    if (!rst_ni) begin
      plane_reg    = 1;
      eps_reg      = 1;
      sum_x        = 0;
      sum_x2       = 0;
      n_stat       = 0;
      mean_q       = 0;
      inv_std      = 0;
      pos_in_plane = 0;
      cur_chan     = 0;
      want_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_PLANE_SIZE) plane_reg = cfg_data_i[PLANE_W-1:0];
        else if (cfg_idx_i == CFG_EPSILON) eps_reg = cfg_data_i[EPS_W-1:0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        x  = s_axis_tdata[15:0];
        ch = s_axis_tdata[21:16];
        if (s_axis_tuser == KIND_AFFINE) begin
          gamma_tbl[ch] = s_axis_tdata[37:22];
          beta_tbl[ch]  = s_axis_tdata[53:38];
        end else if (s_axis_tuser == KIND_STAT) begin
          if (n_stat < MAX_ELEMS) begin
            sum_x  = sum_x + longint'(x);
            sum_x2 = sum_x2 + longint'(longint'(x) * longint'(x));
            n_stat++;
          end
          if (s_axis_tlast) begin
            // close the pass: mean, variance, reciprocal root
            n = (n_stat != 0) ? n_stat : 1;
            q = sum_x / longint'(n);
            if (sum_x < 0 && (sum_x % longint'(n)) != 0) q = q - 1;
            mean_q = q;
            e2     = sum_x2 / n;
            msq    = q * q;
            var_v  = (e2 > msq) ? e2 - msq : 0;
            v      = var_v + eps_reg;
            if (v == 0) begin
              inv_std = 24'hFFFFFF;
            end else begin
              r = floor_root((64'd1 << 48) / v);
              inv_std = (r > 24'hFFFFFF) ? 24'hFFFFFF : r;
            end
            sum_x  = 0;
            sum_x2 = 0;
            n_stat = 0;
          end
        end else if (s_axis_tuser == KIND_NORM) begin
          d = longint'(x) - mean_q;
          p = d * inv_std * longint'(gamma_tbl[cur_chan])
              + (longint'(beta_tbl[cur_chan]) <<< 28) + (64'sd1 <<< 27);
          y = p >>> 28;
          res.clip = 1'b0;
          if (y > 32767) begin
            y = 32767;
            res.clip = 1'b1;
          end
          if (y < -32768) begin
            y = -32768;
            res.clip = 1'b1;
          end
          res.value = y[15:0];
          res.eog   = s_axis_tlast;
          want_q.push_back(res);
          // advance plane and channel position
          ps = (plane_reg == 0) ? 1 : plane_reg;
          if (ps > MAX_PLANE) ps = MAX_PLANE;
          if (s_axis_tlast) begin
            pos_in_plane = 0;
            cur_chan     = 0;
          end else begin
            pos_in_plane++;
            if (pos_in_plane >= ps) begin
              pos_in_plane = 0;
              cur_chan     = (cur_chan + 1) % NUM_CHAN;
            end
          end
        end
        // kind 3 falls through: ignored
      end
      // output side: compare with oldest expectation
      if (m_axis_tvalid && m_axis_tready) begin
        result_count++;
        if (want_q.size() == 0) begin
          report("unexpected result", 0, m_axis_tdata);
        end else begin
          res = want_q.pop_front();
          if (res.clip) clip_count++;
          if (m_axis_tdata !== res.value) report("value", res.value, m_axis_tdata);
          if (m_axis_tlast !== res.eog)   report("end_of_group", res.eog, m_axis_tlast);
          if (m_axis_tuser !== res.clip)  report("clipped", res.clip, m_axis_tuser);
        end
      end
    end
    pending = want_q.size();
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for group_norm_two_pass
// Loads every channel's affine pair, runs directed corner cases, then many
// random statistics/normalize passes under several plane sizes and epsilons,
// with bursty input, a varying output stall pattern and one long hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import gn_pkg::*;

  localparam int TOTAL_ITEMS = 650;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 300;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [TDATA_W-1:0]    s_axis_tdata = '0;
  logic [1:0]            s_axis_tuser = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [SAMPLE_W-1:0]   m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;

  int fail_count, pending, result_count, clip_count;
  int items_sent = 0;
  int burst_left = 0;
  int hold_req = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int stall_span = 0;
  int cycles = 0;
  int plane_eff = 1;

  group_norm_two_pass DUT (.*);

  group_norm_checker u_checker (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: stall pattern changes every stretch, plus requested hold-offs
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (stall_span == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_span = $urandom_range(10, 60);
      end
      stall_span--;
      case (stall_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= $urandom_range(0, 1);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // offer one item, bursts separated by random gaps
  task automatic send_item(logic [1:0] kind, logic [15:0] x, logic [5:0] ch,
                           logic [15:0] g, logic [15:0] b, logic lst);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, b, g, ch, x};
    s_axis_tuser  <= kind;
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // stop offering and let every expected result arrive, then settle
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  task automatic set_config(int ps, int eps);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_PLANE_SIZE;
    cfg_data_i <= ps[15:0];
    @(negedge clk_i);
    cfg_idx_i  <= CFG_EPSILON;
    cfg_data_i <= eps[15:0];
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    plane_eff = (ps[12:0] == 0) ? 1 : ((ps[12:0] > MAX_PLANE) ? MAX_PLANE : ps[12:0]);
  endtask

  function automatic logic [15:0] pick_sample(int center, int spread);
    int s;
    if ($urandom_range(0, 7) == 0) return 16'($urandom());
    s = center + $urandom_range(0, 2 * spread) - spread;
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    return s[15:0];
  endfunction

  // one statistics pass and one normalize pass, optionally with noise items
  task automatic run_group(int n_stat, int n_norm, bit noisy, bit close_norm);
    int center, spread;
    center = $signed(16'($urandom()));
    spread = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 3000);
    for (int i = 0; i < n_stat; i++) begin
      if (noisy && $urandom_range(0, 9) == 0)
        send_item(2'd3, 16'($urandom()), 6'($urandom()), 16'($urandom()),
                  16'($urandom()), 1'($urandom()));
      if (noisy && $urandom_range(0, 12) == 0)
        send_item(KIND_AFFINE, 16'($urandom()), 6'($urandom()), 16'($urandom()),
                  16'($urandom()), 1'($urandom()));
      send_item(KIND_STAT, pick_sample(center, spread), 6'($urandom()),
                16'($urandom()), 16'($urandom()), i == n_stat - 1);
    end
    for (int i = 0; i < n_norm; i++)
      send_item(KIND_NORM, pick_sample(center, spread), 6'($urandom()),
                16'($urandom()), 16'($urandom()), close_norm && (i == n_norm - 1));
  endtask

  int ps_list  [8] = '{1, 2, 3, 0, 8191, 5, 4096, 4};
  int eps_list [8] = '{1, 0, 65535, 40, 1000, 7, 0, 300};

  initial begin
    int nch, nn, ns;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // fill both tables so no normalize item reads an unwritten entry
    for (int c = 0; c < NUM_CHAN; c++)
      send_item(KIND_AFFINE, 16'($urandom()), 6'(c), 16'($urandom()),
                16'($urandom()), c == 5);
    send_item(KIND_AFFINE, 16'h8000, 6'd63, 16'h7FFF, 16'h8000, 1'b1);
    send_item(KIND_AFFINE, 16'h7FFF, 6'd0, 16'h8000, 16'h7FFF, 1'b0);

    // directed: normalize before any statistics gives beta
    send_item(KIND_NORM, 16'h7FFF, 6'd0, 16'd0, 16'd0, 1'b1);
    send_item(2'd3, 16'hFFFF, 6'h3F, 16'hFFFF, 16'hFFFF, 1'b1);
    // extreme samples in one pass
    send_item(KIND_STAT, 16'h8000, 6'd0, 16'd0, 16'd0, 1'b0);
    send_item(KIND_STAT, 16'h7FFF, 6'd0, 16'd0, 16'd0, 1'b0);
    send_item(KIND_STAT, 16'h0000, 6'd0, 16'd0, 16'd0, 1'b1);
    send_item(KIND_NORM, 16'h8000, 6'd0, 16'd0, 16'd0, 1'b0);
    send_item(KIND_NORM, 16'h7FFF, 6'd0, 16'd0, 16'd0, 1'b0);
    send_item(KIND_NORM, 16'h0000, 6'd0, 16'd0, 16'd0, 1'b1);
    // zero variance with zero epsilon saturates the reciprocal root
    set_config(1, 0);
    for (int i = 0; i < 4; i++)
      send_item(KIND_STAT, 16'h0123, 6'd0, 16'd0, 16'd0, i == 3);
    send_item(KIND_NORM, 16'h0123, 6'd0, 16'd0, 16'd0, 1'b0);
    send_item(KIND_NORM, 16'h0124, 6'd0, 16'd0, 16'd0, 1'b0);
    send_item(KIND_NORM, 16'h0122, 6'd0, 16'd0, 16'd0, 1'b1);
    // channel counter wraps after the last channel
    set_config(1, 1);
    run_group(4, 70, 1'b0, 1'b1);

    // random phases over several settings
    for (int ph = 0; items_sent < TOTAL_ITEMS; ph++) begin
      set_config(ps_list[ph % 8], eps_list[ph % 8]);
      if (ph == 2) begin
        // long receiver hold-off while the sender keeps going
        run_group(8, 0, 1'b0, 1'b0);
        hold_req = 400;
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        run_group(0, 40, 1'b0, 1'b1);
        drain();
      end
      for (int g = 0; g < 4 && items_sent < TOTAL_ITEMS; g++) begin
        if (plane_eff >= 64) begin
          nn = $urandom_range(5, 20);
        end else begin
          nch = $urandom_range(1, (24 / plane_eff) > 1 ? 24 / plane_eff : 1);
          nn  = plane_eff * nch;
        end
        ns = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 24) : nn;
        run_group(ns, nn, $urandom_range(0, 2) == 0, $urandom_range(0, 5) != 0);
      end
    end

    drain();
    $display("Drove %0d items over plane sizes 0..8191 and epsilons 0..65535;",
             items_sent);
    $display("checked %0d results, %0d of them saturated.", result_count, clip_count);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
